@@ rtl/tst_pkg.sv @@
// Shared types and constants of the task slot table.
// No dependencies; every other file of the block depends on this package.
package tst_pkg;

   localparam int SLOT_COUNT  = 16;   // number of task slots, 2 to 256
   localparam int SLOT_W      = 8;
   localparam int WORD_W      = 32;
   localparam int BYTES_W     = 24;
   localparam int COUNT_W     = 9;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [1:0] {
      ACT_CREATE  = 2'd0,
      ACT_REMOVE  = 2'd1,
      ACT_RUN     = 2'd2,
      ACT_SUSPEND = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_FREE      = 2'd0,
      ST_READY     = 2'd1,
      ST_RUNNING   = 2'd2,
      ST_SUSPENDED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RC_OK  = 2'd0,
      RC_NOP = 2'd1,
      RC_ERR = 2'd2
   } result_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_BUSY,
      CTL_RESP
   } ctl_state_type;

   // register index, taken from paddr[2]
   typedef enum logic {
      REG_STACK_TOP   = 1'b0,
      REG_STACK_BYTES = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [WORD_W-1:0]  stack_region_top;
      logic [BYTES_W-1:0] stack_bytes_per_task;
   } cfg_type;

   // transaction token that walks down the row of slot cells
   typedef struct packed {
      logic               valid;
      action_type         action;
      logic [SLOT_W-1:0]  slot;
      logic [WORD_W-1:0]  entry;
      logic [WORD_W-1:0]  argument;
      logic [WORD_W-1:0]  offset;        // cell index * stack bytes, mod 2^32
      logic               claimed;
      logic [SLOT_W-1:0]  claim_slot;
      logic [WORD_W-1:0]  claim_offset;
      logic               hit;           // targeted slot accepted the action
      logic [WORD_W-1:0]  run_entry;
      logic [WORD_W-1:0]  run_argument;
   } tok_type;

endpackage

@@ rtl/tst_if.sv @@
// Valid/ready channel interfaces for requests and responses.
// Depends on tst_pkg.
interface tst_req_if;
   logic                       valid;
   logic                       ready;
   tst_pkg::action_type        action;
   logic [tst_pkg::SLOT_W-1:0] slot_id;
   logic [tst_pkg::WORD_W-1:0] entry_address;
   logic [tst_pkg::WORD_W-1:0] entry_argument;

   modport source (output valid, action, slot_id, entry_address, entry_argument,
                   input ready);
   modport sink   (input valid, action, slot_id, entry_address, entry_argument,
                   output ready);
endinterface

interface tst_rsp_if;
   logic                        valid;
   logic                        ready;
   tst_pkg::result_type         result_code;
   logic [tst_pkg::SLOT_W-1:0]  assigned_slot;
   logic [tst_pkg::WORD_W-1:0]  stack_top;
   logic [tst_pkg::BYTES_W-1:0] stack_bytes;
   logic [tst_pkg::WORD_W-1:0]  run_entry;
   logic [tst_pkg::WORD_W-1:0]  run_argument;
   logic                        current_valid;
   logic [tst_pkg::SLOT_W-1:0]  current_slot;
   logic [tst_pkg::COUNT_W-1:0] live_count;

   modport source (output valid, result_code, assigned_slot, stack_top, stack_bytes,
                   run_entry, run_argument, current_valid, current_slot, live_count,
                   input ready);
   modport sink   (input valid, result_code, assigned_slot, stack_top, stack_bytes,
                   run_entry, run_argument, current_valid, current_slot, live_count,
                   output ready);
endinterface

@@ rtl/tst_csr.sv @@
// APB-style configuration registers: stack region top and per-task stack size.
// Depends on tst_pkg.
module tst_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tst_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tst_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tst_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready,
   output tst_pkg::cfg_type                cfg
);
   import tst_pkg::*;

   logic [WORD_W-1:0]  top_ff, top_in;
   logic [BYTES_W-1:0] bytes_ff, bytes_in;
   reg_index_type      reg_index;
   logic               wr_en;

   assign reg_index = reg_index_type'(paddr[CSR_ADDR_W-1]);
   assign wr_en     = psel & penable & pwrite;
   assign pready    = 1'b1;

   always_comb begin
      top_in   = top_ff;
      bytes_in = bytes_ff;
      prdata   = '0;
      unique case (reg_index)
         REG_STACK_TOP: begin
            prdata = top_ff;
            if (wr_en) top_in = pwdata[WORD_W-1:0];
         end
         REG_STACK_BYTES: begin
            prdata = {{(CSR_DATA_W-BYTES_W){1'b0}}, bytes_ff};
            if (wr_en) bytes_in = pwdata[BYTES_W-1:0];
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff   <= '0;
         bytes_ff <= BYTES_W'(4096);
      end else begin
         top_ff   <= top_in;
         bytes_ff <= bytes_in;
      end
   end

   assign cfg.stack_region_top     = top_ff;
   assign cfg.stack_bytes_per_task = bytes_ff;

endmodule

@@ rtl/tst_cell.sv @@
// One task slot: status, entry and argument, plus the token stage to the next cell.
// Depends on tst_pkg.
module tst_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [tst_pkg::SLOT_W-1:0]    cell_index,
   input  logic [tst_pkg::BYTES_W-1:0]   stack_bytes,
   input  tst_pkg::tok_type              tok_i,
   output tst_pkg::tok_type              tok_o
);
   import tst_pkg::*;

   status_type        status_ff, status_in;
   logic [WORD_W-1:0] entry_ff, argument_ff;
   logic              write_en;
   tok_type           tok_ff, tok_in;

   always_comb begin
      tok_in        = tok_i;
      tok_in.offset = tok_i.offset + {{(WORD_W-BYTES_W){1'b0}}, stack_bytes};
      status_in     = status_ff;
      write_en      = 1'b0;
      if (tok_i.valid) begin
         if (tok_i.action == ACT_CREATE) begin
            // first free cell on the way takes the new task
            if (tok_i.entry != '0 && !tok_i.claimed && status_ff == ST_FREE) begin
               status_in           = ST_READY;
               write_en            = 1'b1;
               tok_in.claimed      = 1'b1;
               tok_in.claim_slot   = cell_index;
               tok_in.claim_offset = tok_i.offset;
            end
         end else if (tok_i.slot == cell_index && status_ff != ST_FREE) begin
            case (tok_i.action)
               ACT_REMOVE: begin
                  if (cell_index != '0) begin
                     status_in  = ST_FREE;
                     tok_in.hit = 1'b1;
                  end
               end
               ACT_RUN: begin
                  status_in           = ST_RUNNING;
                  tok_in.hit          = 1'b1;
                  tok_in.run_entry    = entry_ff;
                  tok_in.run_argument = argument_ff;
               end
               default: begin
                  status_in  = ST_SUSPENDED;
                  tok_in.hit = 1'b1;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= ST_FREE;
         tok_ff.valid <= 1'b0;
      end else begin
         status_ff    <= status_in;
         tok_ff.valid <= tok_in.valid;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (write_en) begin
         entry_ff    <= tok_i.entry;
         argument_ff <= tok_i.argument;
      end
      tok_ff.action       <= tok_in.action;
      tok_ff.slot         <= tok_in.slot;
      tok_ff.entry        <= tok_in.entry;
      tok_ff.argument     <= tok_in.argument;
      tok_ff.offset       <= tok_in.offset;
      tok_ff.claimed      <= tok_in.claimed;
      tok_ff.claim_slot   <= tok_in.claim_slot;
      tok_ff.claim_offset <= tok_in.claim_offset;
      tok_ff.hit          <= tok_in.hit;
      tok_ff.run_entry    <= tok_in.run_entry;
      tok_ff.run_argument <= tok_in.run_argument;
   end

   assign tok_o = tok_ff;

endmodule

@@ rtl/task_slot_table.sv @@
// Top level of the task slot table: request/response channels, CSR port,
// row of slot cells and the result stage. Depends on tst_pkg, tst_if,
// tst_csr and tst_cell.
//
// Usage:
//  - req_chan carries one command (create, remove, run, suspend) per
//    transaction; rsp_chan returns exactly one result per command.
//  - One command is in flight at a time. Once accepted, a token is loaded
//    into a head register and walks down the row of SLOT_COUNT cells, one
//    cell per cycle. Each cell owns one slot; the token claims the lowest
//    free slot on create, or hits the addressed slot on the other actions.
//    The stack offset (index * stack size) is accumulated cell by cell.
//  - A result reaches rsp valid through the head register, the row of cells
//    and the result register; the command rate is set by the length of the
//    cell row, as a new command waits until the response is delivered.
//  - req ready is high only while the block is idle.
//  - If the sink stalls, the result is held in the output register and no
//    new command is taken until it is delivered.
//  - Reset (synchronous) frees all slots, clears the live count and the
//    current task, and loads the CSRs with top = 0, stack size = 4096.
//    Entry/argument storage is not cleared; it is only read for used slots.
//  - CSRs: 0x0 stack region top, 0x4 stack bytes per task; write while idle.
module task_slot_table (
   input  logic                            clock,
   input  logic                            reset,
   tst_req_if.sink                         req_chan,
   tst_rsp_if.source                       rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tst_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [tst_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [tst_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                            pready
);
   import tst_pkg::*;

   cfg_type           cfg;
   ctl_state_type     state_ff, state_in;
   logic              req_accept, rsp_accept;

   tok_type           head_ff;
   tok_type           chain [SLOT_COUNT];
   tok_type           tail;
   logic [SLOT_COUNT:0] tok_valid_vec;

   // bookkeeping registers
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               cur_flag_ff, cur_flag_in;
   logic [SLOT_W-1:0]  cur_slot_ff, cur_slot_in;

   // result register
   result_type         rc_ff, rc_in;
   logic [SLOT_W-1:0]  aslot_ff, aslot_in;
   logic [WORD_W-1:0]  stop_ff, stop_in;
   logic [BYTES_W-1:0] sbytes_ff, sbytes_in;
   logic [WORD_W-1:0]  rentry_ff, rentry_in;
   logic [WORD_W-1:0]  rarg_ff, rarg_in;

   tst_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign req_accept = req_chan.valid & req_chan.ready;
   assign rsp_accept = rsp_chan.valid & rsp_chan.ready;

   // ---------------- control FSM ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      unique case (state_ff)
         CTL_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) state_in = CTL_BUSY;
         end
         CTL_BUSY: begin
            if (tail.valid) state_in = CTL_RESP;
         end
         CTL_RESP: begin
            rsp_chan.valid = 1'b1;
            if (rsp_chan.ready) state_in = CTL_IDLE;
         end
         default: state_in = CTL_IDLE;
      endcase
   end

   // ---------------- head of the row ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff.valid <= 1'b0;
      end else begin
         head_ff.valid <= req_accept;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         head_ff.action       <= req_chan.action;
         head_ff.slot         <= req_chan.slot_id;
         head_ff.entry        <= req_chan.entry_address;
         head_ff.argument     <= req_chan.entry_argument;
         head_ff.offset       <= '0;
         head_ff.claimed      <= 1'b0;
         head_ff.claim_slot   <= '0;
         head_ff.claim_offset <= '0;
         head_ff.hit          <= 1'b0;
         head_ff.run_entry    <= '0;
         head_ff.run_argument <= '0;
      end
   end

   // ---------------- row of slot cells ----------------
   for (genvar k = 0; k < SLOT_COUNT; k++) begin : g_cell
      if (k == 0) begin : g_first
         tst_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cell_index  (SLOT_W'(k)),
            .stack_bytes (cfg.stack_bytes_per_task),
            .tok_i       (head_ff),
            .tok_o       (chain[k])
         );
      end else begin : g_next
         tst_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cell_index  (SLOT_W'(k)),
            .stack_bytes (cfg.stack_bytes_per_task),
            .tok_i       (chain[k-1]),
            .tok_o       (chain[k])
         );
      end
      assign tok_valid_vec[k+1] = chain[k].valid;
   end
   assign tok_valid_vec[0] = head_ff.valid;
   assign tail = chain[SLOT_COUNT-1];

   // ---------------- result stage ----------------
   always_comb begin
      count_in    = count_ff;
      cur_flag_in = cur_flag_ff;
      cur_slot_in = cur_slot_ff;
      rc_in       = RC_NOP;
      aslot_in    = '0;
      stop_in     = '0;
      sbytes_in   = '0;
      rentry_in   = '0;
      rarg_in     = '0;
      if (tail.action == ACT_CREATE) begin
         if (tail.entry == '0) begin
            rc_in = RC_ERR;
         end else if (tail.claimed) begin
            // a claim implies a free slot, so the count cannot be full here
            rc_in     = RC_OK;
            count_in  = count_ff + COUNT_W'(1);
            aslot_in  = tail.claim_slot;
            stop_in   = cfg.stack_region_top - tail.claim_offset;
            sbytes_in = cfg.stack_bytes_per_task;
         end
      end else if (tail.hit) begin
         rc_in = RC_OK;
         case (tail.action)
            ACT_REMOVE: begin
               // current task register stays as is
               if (count_ff != '0) count_in = count_ff - COUNT_W'(1);
            end
            ACT_RUN: begin
               cur_flag_in = 1'b1;
               cur_slot_in = tail.slot;
               rentry_in   = tail.run_entry;
               rarg_in     = tail.run_argument;
            end
            default: begin
               // suspend clears current even when another slot was current
               cur_flag_in = 1'b0;
               cur_slot_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         cur_flag_ff <= 1'b0;
         cur_slot_ff <= '0;
      end else if (tail.valid) begin
         count_ff    <= count_in;
         cur_flag_ff <= cur_flag_in;
         cur_slot_ff <= cur_slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tail.valid) begin
         rc_ff     <= rc_in;
         aslot_ff  <= aslot_in;
         stop_ff   <= stop_in;
         sbytes_ff <= sbytes_in;
         rentry_ff <= rentry_in;
         rarg_ff   <= rarg_in;
      end
   end

   assign rsp_chan.result_code   = rc_ff;
   assign rsp_chan.assigned_slot = aslot_ff;
   assign rsp_chan.stack_top     = stop_ff;
   assign rsp_chan.stack_bytes   = sbytes_ff;
   assign rsp_chan.run_entry     = rentry_ff;
   assign rsp_chan.run_argument  = rarg_ff;
   assign rsp_chan.current_valid = cur_flag_ff;
   assign rsp_chan.current_slot  = cur_flag_ff ? cur_slot_ff : '0;
   assign rsp_chan.live_count    = count_ff;

`ifndef SYNTH
   // only one token may be in the cell row at any time
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid_vec))
      else $error("more than one token in the slot row");

   // an accepted request enters the head of the row next cycle
   a_head_load: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> head_ff.valid)
      else $error("accepted request did not reach the row head");

   // live count stays within the table size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(SLOT_COUNT))
      else $error("live count exceeds slot count");

   // no token may be in flight while a response waits or the block is idle
   a_token_busy: assert property (@(posedge clock) disable iff (reset)
      (tok_valid_vec[SLOT_COUNT:1] != '0) |-> (state_ff == CTL_BUSY))
      else $error("token in the row outside the busy state");
`endif

endmodule
